>>> rtl/hse_pkg.sv
// ----------------------------------------------------------------------------
// hse_pkg: shared types and constants of the heap sort engine
// Key width, store depth, counter width, control state and cell control.
// ----------------------------------------------------------------------------
package hse_pkg;

	localparam int MAX_KEYS = 64;
	localparam int KEY_W    = 32;
	localparam int CNT_W    = $clog2(MAX_KEYS + 1);

	typedef logic signed [KEY_W-1:0] key_t;
	typedef logic [CNT_W-1:0]        cnt_t;

	typedef enum logic [0:0] {
		ST_FILL,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic ins;
		logic shf;
		key_t key;
	} cell_ctl_t;

endpackage

>>> rtl/hse_cell.sv
// ----------------------------------------------------------------------------
// hse_cell: one slot of the sorting chain
// Holds one key; makes room for an inserted key and shifts left on output.
// ----------------------------------------------------------------------------
module hse_cell (
	input  logic              clk,
	input  hse_pkg::cell_ctl_t ctl,
	input  logic              occ,
	input  logic              slot_free,
	input  hse_pkg::key_t     left_key,
	input  logic              left_gt,
	input  hse_pkg::key_t     right_key,
	output hse_pkg::key_t     key,
	output logic              gt
);

	hse_pkg::key_t key_q;

	assign gt  = occ && ($signed(key_q) > $signed(ctl.key));
	assign key = key_q;

	always_ff @(posedge clk) begin
		if (ctl.ins && (gt || slot_free)) begin
			key_q <= left_gt ? left_key : ctl.key;
		end else if (ctl.shf) begin
			key_q <= right_key;
		end
	end

endmodule

>>> rtl/hse_ctrl.sv
// ----------------------------------------------------------------------------
// hse_ctrl: fill and drain sequencer
// Counts stored keys, flags dropped keys and drives both stream handshakes.
// ----------------------------------------------------------------------------
module hse_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	input  logic               s_tlast,
	input  hse_pkg::key_t      s_key,
	output logic               s_tready,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic               m_tlast,
	output logic               m_tuser,
	output hse_pkg::cell_ctl_t ctl,
	output hse_pkg::cnt_t      count
);

	hse_pkg::state_t state_q, state_d;
	hse_pkg::cnt_t   count_q;
	logic            dropped_q;
	logic            in_acc, out_acc, full, out_end;

	assign full    = (count_q == hse_pkg::CNT_W'(hse_pkg::MAX_KEYS));
	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;
	assign out_end = out_acc && (count_q == hse_pkg::CNT_W'(1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hse_pkg::ST_FILL: begin
				if (in_acc && s_tlast) state_d = hse_pkg::ST_DRAIN;
			end
			hse_pkg::ST_DRAIN: begin
				if (out_end) state_d = hse_pkg::ST_FILL;
			end
			default: state_d = hse_pkg::ST_FILL;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		unique case (state_q)
			hse_pkg::ST_FILL:  s_tready = 1'b1;
			hse_pkg::ST_DRAIN: m_tvalid = 1'b1;
			default: ;
		endcase
	end

	assign m_tlast = (count_q == hse_pkg::CNT_W'(1));
	assign m_tuser = dropped_q;
	assign count   = count_q;

	always_comb begin
		ctl.ins = in_acc && !full;
		ctl.shf = out_acc;
		ctl.key = s_key;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= hse_pkg::ST_FILL;
			count_q   <= '0;
			dropped_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.ins) begin
				count_q <= count_q + hse_pkg::CNT_W'(1);
			end else if (out_acc) begin
				count_q <= count_q - hse_pkg::CNT_W'(1);
			end
			if (in_acc && full) begin
				dropped_q <= 1'b1;
			end else if (out_end) begin
				dropped_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/heap_sort_engine_top.sv
// ----------------------------------------------------------------------------
// heap_sort_engine_top: sorting engine for sets of signed Q16.16 keys
// Latency: first sorted key is offered the cycle after the closing key.
// Throughput: one key per cycle in, then one sorted key per cycle out while m_tready is high.
// A set of N keys occupies the engine until its last sorted key is taken.
// The insertion chain of cells sets the rate: one compare per cell per key.
// Reset: asynchronous, active low; empties the set and clears the drop flag.
// ----------------------------------------------------------------------------
module heap_sort_engine_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] key
	input  logic        s_tlast,  // last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [31:0] sorted_key
	output logic        m_tlast,  // final_res
	output logic        m_tuser   // [0] overflow
);

	hse_pkg::cell_ctl_t ctl;
	hse_pkg::cnt_t      count;
	hse_pkg::key_t      cell_key [hse_pkg::MAX_KEYS];
	logic               cell_gt  [hse_pkg::MAX_KEYS];

	hse_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_key    (hse_pkg::key_t'(s_tdata)),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.ctl      (ctl),
		.count    (count)
	);

	for (genvar i = 0; i < hse_pkg::MAX_KEYS; i++) begin : g_cell
		hse_pkg::key_t left_key, right_key;
		logic          left_gt;

		if (i == 0) begin : g_head
			assign left_key = ctl.key;
			assign left_gt  = 1'b0;
		end else begin : g_body
			assign left_key = cell_key[i-1];
			assign left_gt  = cell_gt[i-1];
		end

		if (i == hse_pkg::MAX_KEYS - 1) begin : g_tail
			assign right_key = cell_key[i];
		end else begin : g_mid
			assign right_key = cell_key[i+1];
		end

		hse_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.occ       (hse_pkg::CNT_W'(i) < count),
			.slot_free (hse_pkg::CNT_W'(i) == count),
			.left_key  (left_key),
			.left_gt   (left_gt),
			.right_key (right_key),
			.key       (cell_key[i]),
			.gt        (cell_gt[i])
		);
	end

	assign m_tdata = cell_key[0];

endmodule

>>> rtl/hse_checker.sv
// ----------------------------------------------------------------------------
// hse_checker: port-level checks of the heap sort engine
// Watches the sort order and the fill and drain sequence at the ports.
// ----------------------------------------------------------------------------
module hse_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tlast
);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input taken while draining");

	a_drain_starts: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> m_tvalid)
		else $error("no result after closing transaction");

	a_drain_ends: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> !m_tvalid && s_tready)
		else $error("drain did not end after final transaction");

	a_ascending: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=>
			m_tvalid && ($signed(m_tdata) >= $signed($past(m_tdata))))
		else $error("results out of order");

endmodule

bind heap_sort_engine_top hse_checker u_hse_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
